// ===== hw/rtl/gtm_pkg.sv =====
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared types and constants for the Goertzel tone magnitude block.
// ----------------------------------------------------------------------------
package gtm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RECUR_W   = 48;
  localparam int COEF_W    = 16;
  localparam int LEN_W     = 13;
  localparam int MAX_BLOCK = 4096;
  localparam int MAG_W     = 32;

  // register map, word index
  localparam logic [1:0] REG_COS = 2'd0;
  localparam logic [1:0] REG_SIN = 2'd1;
  localparam logic [1:0] REG_LEN = 2'd2;

  localparam logic signed [COEF_W-1:0] COS_RST = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SIN_RST = 16'sd0;
  localparam logic [LEN_W-1:0]         LEN_RST = 13'd256;

  // finished block handed from front to back
  typedef struct packed {
    logic signed [RECUR_W-1:0] prev;
    logic signed [RECUR_W-1:0] prev2;
    logic [LEN_W-1:0]          len;
  } gtm_blk_t;

endpackage

// ===== hw/rtl/goertzel_tone_magnitude.sv =====
// ----------------------------------------------------------------------------
// goertzel_tone_magnitude
// Single-tone Goertzel detector with register-set coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one signed sample per beat (valid/ready). The front takes a
//            new sample only after the last has had its coefficient
//            product and then its recurrence update formed.
//   out_*  : one magnitude beat per finished block (valid/ready).
//   APB    : cos_coeff at 0x0, sin_coeff at 0x4, block_length at 0x8.
// Once it takes a finished block, the back end sets up, forms the power via
//   one 32x32 multiplier, checks for saturation, runs 64 division steps and
//   32 square-root steps, then presents the result.
// Blocks are limited by the serial divider and root in the back end, which
//   takes a new block only once the last result has been accepted.
// A two-entry block queue lets sampling continue while the back end works or
//   while the receiver stalls; when it fills, in_ready drops.
// Reset clears the recurrence, the sample count, the queue and out_valid and
//   restores the register defaults.
// ----------------------------------------------------------------------------
module goertzel_tone_magnitude (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gtm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gtm_pkg::MAG_W-1:0]          out_magnitude,
  output logic                               out_saturated,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic signed [gtm_pkg::COEF_W-1:0] cos_r, sin_r;
  logic [gtm_pkg::LEN_W-1:0]         len_r;
  logic                              wr_en;
  logic                              q_push, q_pop, q_empty, q_full;
  gtm_pkg::gtm_blk_t                 q_in, q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= gtm_pkg::COS_RST;
      sin_r <= gtm_pkg::SIN_RST;
      len_r <= gtm_pkg::LEN_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        gtm_pkg::REG_COS: cos_r <= pwdata[15:0];
        gtm_pkg::REG_SIN: sin_r <= pwdata[15:0];
        gtm_pkg::REG_LEN: len_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      gtm_pkg::REG_COS: prdata = 32'(unsigned'(cos_r));
      gtm_pkg::REG_SIN: prdata = 32'(unsigned'(sin_r));
      gtm_pkg::REG_LEN: prdata = 32'(len_r);
      default:          prdata = '0;
    endcase
  end

  gtm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .cos_coeff    (cos_r),
    .block_length (len_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  gtm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  gtm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .cos_coeff     (cos_r),
    .sin_coeff     (sin_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_magnitude (out_magnitude),
    .out_saturated (out_saturated)
  );

endmodule

// ===== hw/rtl/gtm_fifo.sv =====
// ----------------------------------------------------------------------------
// gtm_fifo
// Two-entry queue of finished blocks between the front and the back.
// ----------------------------------------------------------------------------
module gtm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gtm_pkg::gtm_blk_t push_data,
  input  logic              pop,
  output gtm_pkg::gtm_blk_t head,
  output logic              empty,
  output logic              full
);

  gtm_pkg::gtm_blk_t mem_r [2];
  logic              wptr_r, rptr_r;
  logic [1:0]        cnt_r;

  assign head  = mem_r[rptr_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/gtm_front.sv =====
// ----------------------------------------------------------------------------
// gtm_front
// Sample intake: runs the Goertzel recurrence, counts samples, and hands a
// finished block to the queue.
// ----------------------------------------------------------------------------
module gtm_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gtm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic signed [gtm_pkg::COEF_W-1:0]   cos_coeff,
  input  logic [gtm_pkg::LEN_W-1:0]           block_length,
  input  logic                               q_full,
  output logic                               q_push,
  output gtm_pkg::gtm_blk_t                  q_data
);

  logic                                    busy_r;
  logic signed [gtm_pkg::SAMPLE_W-1:0]     x_r;
  logic signed [63:0]                      prod_r;
  logic signed [gtm_pkg::RECUR_W-1:0]      prev_r, prev_nxt;
  logic signed [gtm_pkg::RECUR_W-1:0]      prev2_r, prev2_nxt;
  logic [gtm_pkg::LEN_W-1:0]               cnt_r, cnt_nxt;
  logic [gtm_pkg::LEN_W-1:0]               len_eff;
  logic signed [63:0]                      term;
  logic signed [63:0]                      s_full;
  logic [gtm_pkg::LEN_W-1:0]               cnt_inc;
  logic                                    accept;
  logic                                    blk_end;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy_r && !q_full;

  // clamp block length to one .. MAX_BLOCK
  always_comb begin
    if (block_length == '0) begin
      len_eff = gtm_pkg::LEN_W'(1);
    end else if (block_length > gtm_pkg::LEN_W'(gtm_pkg::MAX_BLOCK)) begin
      len_eff = gtm_pkg::LEN_W'(gtm_pkg::MAX_BLOCK);
    end else begin
      len_eff = block_length;
    end
  end

  // busy phase: finish the recurrence from the held product
  always_comb begin
    term    = (prod_r + 64'sd4096) >>> 13;
    s_full  = (64'(x_r) <<< 8) + term - 64'(prev2_r);
    cnt_inc = cnt_r + gtm_pkg::LEN_W'(1);
    blk_end = busy_r && (cnt_inc >= len_eff);
    prev_nxt  = prev_r;
    prev2_nxt = prev2_r;
    cnt_nxt   = cnt_r;
    if (busy_r) begin
      if (blk_end) begin
        prev_nxt  = '0;
        prev2_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        prev_nxt  = s_full[gtm_pkg::RECUR_W-1:0];
        prev2_nxt = prev_r;
        cnt_nxt   = cnt_inc;
      end
    end
  end

  assign q_push       = blk_end;
  assign q_data.prev  = s_full[gtm_pkg::RECUR_W-1:0];
  assign q_data.prev2 = prev_r;
  assign q_data.len   = len_eff;

  // on accept: hold sample and coefficient product
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_sample;
      prod_r <= 64'(cos_coeff) * 64'(prev_r);
    end
  end

  // recurrence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      prev_r  <= '0;
      prev2_r <= '0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= accept;
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/gtm_back.sv =====
// ----------------------------------------------------------------------------
// gtm_back
// Block-end evaluation: real/imag parts, power by a shared 32x32 multiplier,
// bit-serial division by the block length and a digit-serial square root.
// ----------------------------------------------------------------------------
module gtm_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  gtm_pkg::gtm_blk_t                q_head,
  output logic                             q_pop,
  input  logic signed [gtm_pkg::COEF_W-1:0] cos_coeff,
  input  logic signed [gtm_pkg::COEF_W-1:0] sin_coeff,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gtm_pkg::MAG_W-1:0]        out_magnitude,
  output logic                             out_saturated
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_COEF = 4'd1;
  localparam logic [3:0] ST_RI   = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]                st_r;
  gtm_pkg::gtm_blk_t         blk_r;
  logic signed [63:0]        pc_r, ps_r;
  logic [49:0]               ar_r, ai_r;
  logic [2:0]                k_r;
  logic [63:0]               prod_r;
  logic [6:0]                sh_r;
  logic [100:0]              acc_r;
  logic [63:0]               dv_r;
  logic [12:0]               rem_r;
  logic [31:0]               root_r;
  logic [34:0]               srem_r;
  logic [5:0]                cnt_r;
  logic [gtm_pkg::MAG_W-1:0] mag_r;
  logic                      sat_r;

  logic signed [65:0]        re_sum;
  logic signed [51:0]        re_v, im_v;
  logic signed [63:0]        im_sum;
  logic [49:0]               mx;
  logic [31:0]               mul_a, mul_b;
  logic [6:0]                mul_sh;
  logic [84:0]               pd;
  logic [13:0]               dt;
  logic                      dbit;
  logic [34:0]               st2;
  logic [34:0]               trial;
  logic                      sbit;

  assign q_pop         = (st_r == ST_IDLE) && !q_empty;
  assign out_valid     = (st_r == ST_OUT);
  assign out_magnitude = mag_r;
  assign out_saturated = sat_r;

  // real and imaginary parts, rounded to nearest (halves up)
  always_comb begin
    re_sum = (66'(blk_r.prev) <<< 14) - 66'(pc_r) + 66'sd8192;
    re_v   = 52'(re_sum >>> 14);
    im_sum = ps_r + 64'sd8192;
    im_v   = 52'(im_sum >>> 14);
  end

  // select multiplier operands: x0*x0, x0*x1 (doubled), x1*x1
  always_comb begin
    mx = (k_r < 3'd3) ? ar_r : ai_r;
    unique case (k_r)
      3'd0, 3'd3: begin
        mul_a = mx[31:0]; mul_b = mx[31:0]; mul_sh = 7'd0;
      end
      3'd1, 3'd4: begin
        mul_a = mx[31:0]; mul_b = 32'(mx[49:32]); mul_sh = 7'd33;
      end
      default: begin
        mul_a = 32'(mx[49:32]); mul_b = 32'(mx[49:32]); mul_sh = 7'd64;
      end
    endcase
  end

  // division and square root steps
  always_comb begin
    pd    = acc_r[100:16];
    dt    = {rem_r, dv_r[63]};
    dbit  = (dt >= 14'(blk_r.len));
    st2   = {srem_r[32:0], dv_r[63:62]};
    trial = 35'({root_r, 2'b01});
    sbit  = (st2 >= trial);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            blk_r <= q_head;
            st_r  <= ST_COEF;
          end
        end
        ST_COEF: begin
          pc_r <= 64'(blk_r.prev2) * 64'(cos_coeff);
          ps_r <= 64'(blk_r.prev2) * 64'(sin_coeff);
          st_r <= ST_RI;
        end
        ST_RI: begin
          ar_r  <= re_v[51] ? 50'(-re_v) : 50'(re_v);
          ai_r  <= im_v[51] ? 50'(-im_v) : 50'(im_v);
          acc_r <= '0;
          k_r   <= 3'd0;
          st_r  <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= 64'(mul_a) * 64'(mul_b);
          sh_r   <= mul_sh;
          st_r   <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_r + (101'(prod_r) << sh_r);
          k_r   <= k_r + 3'd1;
          st_r  <= (k_r == 3'd5) ? ST_CHK : ST_MUL;
        end
        ST_CHK: begin
          if (pd[84:64] >= 21'(blk_r.len)) begin
            mag_r <= '1;
            sat_r <= 1'b1;
            st_r  <= ST_OUT;
          end else begin
            rem_r <= pd[76:64];
            dv_r  <= pd[63:0];
            cnt_r <= '0;
            st_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= dbit ? 13'(dt - 14'(blk_r.len)) : dt[12:0];
          dv_r  <= {dv_r[62:0], dbit};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            root_r <= '0;
            srem_r <= '0;
            st_r   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          srem_r <= sbit ? (st2 - trial) : st2;
          root_r <= {root_r[30:0], sbit};
          dv_r   <= {dv_r[61:0], 2'b00};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
      // latch the root once the last digit is in
      if (st_r == ST_SQRT && cnt_r == 6'd31) begin
        mag_r <= {root_r[30:0], sbit};
        sat_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/gtm_checker.sv =====
// ----------------------------------------------------------------------------
// gtm_checker
// Port-level checks for the Goertzel tone magnitude block.
// ----------------------------------------------------------------------------
module gtm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_magnitude,
  input logic        out_saturated
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude)
      && $stable(out_saturated))
    else $error("result beat changed while stalled");

  // saturation pins the magnitude at full scale
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_magnitude == 32'hFFFF_FFFF)
    else $error("saturated flag without full-scale magnitude");

  // the front cannot take a new sample while it finishes the recurrence for the last
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted on back-to-back cycles");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind goertzel_tone_magnitude gtm_checker u_gtm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_magnitude (out_magnitude),
  .out_saturated (out_saturated)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Goertzel tone magnitude: directed and random sample streams with random
// coefficients and block lengths, checked beat by beat against a bit-exact
// fixed-point model of the recurrence, the power and the integer root.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 5000;

  typedef struct {
    logic [gtm_pkg::MAG_W-1:0] magnitude;
    logic                      saturated;
  } tone_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [gtm_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [gtm_pkg::MAG_W-1:0] out_magnitude;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  goertzel_tone_magnitude uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_magnitude(out_magnitude), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model state and register copies
  longint cos_q14, sin_q14;
  logic [gtm_pkg::LEN_W-1:0] blk_len;
  longint acc_prev, acc_prev2;
  logic [gtm_pkg::LEN_W-1:0] taken;

  logic signed [gtm_pkg::SAMPLE_W-1:0] sample_q[$];
  tone_t tone_q[$];
  int errors = 0;
  bit hold = 1'b0;
  bit beat_seen = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Advance the recurrence by one sample; queue a tone at block end
  task automatic tone_step(logic signed [gtm_pkg::SAMPLE_W-1:0] x);
    longint term, s, n;
    logic [47:0] s48;
    logic signed [79:0] a, b, c, t, re, im;
    logic [127:0] pw, qw;
    tone_t r;
    term = (cos_q14 * acc_prev + 4096) >>> 13;
    s = longint'(x) * 256 + term - acc_prev2;
    s48 = s[47:0];
    acc_prev2 = acc_prev;
    acc_prev = longint'(signed'(s48));
    n = (blk_len == 0) ? 1 :
        ((blk_len > gtm_pkg::MAX_BLOCK) ? gtm_pkg::MAX_BLOCK : blk_len);
    taken = taken + 1'b1;
    if (taken < n) return;
    a = acc_prev;
    b = acc_prev2;
    c = cos_q14;
    t = a * 80'sd16384 - b * c + 80'sd8192;
    re = t >>> 14;
    c = sin_q14;
    t = b * c + 80'sd8192;
    im = t >>> 14;
    if (re < 0) re = -re;
    if (im < 0) im = -im;
    pw = (128'(re) * 128'(re) + 128'(im) * 128'(im)) >> 16;
    if ((pw >> 64) >= 128'(n)) begin
      r.magnitude = '1;
      r.saturated = 1'b1;
    end else begin
      qw = pw / 128'(n);
      r.magnitude = gtm_pkg::MAG_W'(int_root(qw[63:0]));
      r.saturated = 1'b0;
    end
    tone_q.push_back(r);
    acc_prev = 0;
    acc_prev2 = 0;
    taken = '0;
  endtask

  // Register write: setup then access cycle
  task automatic reg_write(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == gtm_pkg::REG_COS) cos_q14 = longint'(signed'(val[15:0]));
    else if (idx == gtm_pkg::REG_SIN) sin_q14 = longint'(signed'(val[15:0]));
    else if (idx == gtm_pkg::REG_LEN) blk_len = val[gtm_pkg::LEN_W-1:0];
  endtask

  // Wait until every sample is taken and every tone has come, then settle
  task automatic drain();
    while (sample_q.size() != 0 || in_valid || tone_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 5))
      0: return 32'(16384);
      1: return 32'(-16384);
      2: return 32'h7FFF;
      3: return 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [gtm_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps
  int gap_left = 0;
  int burst_left = 4;
  always @(posedge clk) begin : sender
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tone_step(in_sample);
        beat_seen = 1'b1;
      end
      if (!in_valid || in_ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() != 0 && !hold) begin
          in_sample <= sample_q.pop_front();
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= nv;
      end
    end
  end

  // Receiver: stall on a rotating pattern, reloaded now and then
  logic [15:0] stall_pat = 16'hFFFF;
  always @(posedge clk) begin : receiver
    tone_t e;
    if (rst_n && out_valid && out_ready) begin
      beat_seen = 1'b1;
      if (tone_q.size() == 0) begin
        $display("%0t: tone beat with none expected: mag %0d sat %0b",
                 $realtime, out_magnitude, out_saturated);
        errors++;
      end else begin
        e = tone_q.pop_front();
        if (out_magnitude !== e.magnitude) begin
          $display("%0t: magnitude expected %0d actual %0d",
                   $realtime, e.magnitude, out_magnitude);
          errors++;
        end
        if (out_saturated !== e.saturated) begin
          $display("%0t: saturated expected %0b actual %0b",
                   $realtime, e.saturated, out_saturated);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 63) == 0)
      stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    out_ready <= rst_n && stall_pat[0];
  end

  // Watchdog: count cycles with no beat on any port
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (beat_seen || psel) idle_cycles = 0;
    else idle_cycles++;
    beat_seen = 1'b0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int n_items;
    logic [31:0] lv;
    cos_q14 = gtm_pkg::COS_RST;
    sin_q14 = gtm_pkg::SIN_RST;
    blk_len = gtm_pkg::LEN_RST;
    acc_prev = 0;
    acc_prev2 = 0;
    taken = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults, extreme samples, then lower the length mid-block
    sample_q.push_back(16'sh7FFF);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh0000);
    drain();
    reg_write(gtm_pkg::REG_LEN, 32'd1);
    sample_q.push_back(16'sh7FFF);
    drain();
    // Zero length acts as one; out-of-range index is ignored
    reg_write(gtm_pkg::REG_LEN, 32'd0);
    reg_write(3, 32'hFFFF_FFFF);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh1234);
    drain();
    // Length beyond the maximum is clamped; then lowered to end the block
    reg_write(gtm_pkg::REG_LEN, 32'd5000);
    sample_q.push_back(16'sh4000);
    sample_q.push_back(16'shC000);
    drain();
    reg_write(gtm_pkg::REG_LEN, 32'd2);
    sample_q.push_back(16'sh0001);
    drain();
    // Coefficients past one: recurrence wraps and the magnitude saturates
    reg_write(gtm_pkg::REG_COS, 32'h0000_8000);
    reg_write(gtm_pkg::REG_SIN, 32'h0000_7FFF);
    reg_write(gtm_pkg::REG_LEN, 32'd14);
    for (int i = 0; i < 14; i++) sample_q.push_back(i[0] ? 16'sh8000 : 16'sh7FFF);
    drain();

    // Random phases
    for (int ph = 0; ph < 17; ph++) begin
      reg_write(gtm_pkg::REG_COS, pick_coeff());
      reg_write(gtm_pkg::REG_SIN, pick_coeff());
      case ($urandom_range(0, 9))
        0: lv = 32'd0;
        1: lv = 32'd4096;
        2: lv = 32'h1FFF;
        3: lv = $urandom_range(40, 300);
        default: lv = $urandom_range(1, 20);
      endcase
      lv[31:13] = $urandom;
      reg_write(gtm_pkg::REG_LEN, lv);
      n_items = $urandom_range(20, 70);
      for (int i = 0; i < n_items; i++) begin
        sample_q.push_back(pick_sample());
        if (i == n_items / 2 && ph % 4 == 1) begin
          // Pause the sender until every tone has come
          while (sample_q.size() != 0 || in_valid) @(posedge clk);
          hold = 1'b1;
          while (tone_q.size() != 0) @(posedge clk);
          hold = 1'b0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gtm_pkg.sv
hw/rtl/gtm_fifo.sv
hw/rtl/gtm_front.sv
hw/rtl/gtm_back.sv
hw/rtl/goertzel_tone_magnitude.sv
hw/rtl/gtm_checker.sv
dv/tb_top.sv
